// ===== src/mtq_pkg.sv =====
// Shared types and constants for the motor torque from power solver.
package mtq_pkg;

  localparam int COEF_W = 48;
  localparam int IDX_W  = 3;

  typedef enum logic [1:0] {
    ST_TWO_ROOTS = 2'd0,
    ST_ONE_ROOT  = 2'd1,
    ST_NO_ROOT   = 2'd2,
    ST_K4_ZERO   = 2'd3
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_CONST     = 3'd0,
    REG_TORQUE    = 3'd1,
    REG_SPEED     = 3'd2,
    REG_CROSS     = 3'd3,
    REG_TORQUE_SQ = 3'd4,
    REG_SPEED_SQ  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] k0;
    logic signed [COEF_W-1:0] k1;
    logic signed [COEF_W-1:0] k2;
    logic signed [COEF_W-1:0] k3;
    logic signed [COEF_W-1:0] k4;
    logic signed [COEF_W-1:0] k5;
  } coef_t;

  typedef struct packed {
    logic               k4_zero;
    logic signed [63:0] b;
    logic [30:0]        wsq;
    logic signed [63:0] lin;
    logic signed [15:0] t0;
  } front_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [63:0] b;
    logic signed [15:0] t0;
  } side_t;

endpackage

// ===== src/mtq_ifs.sv =====
// Handshake channel interfaces for samples, results and configuration writes.
interface mtq_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_power;
  logic signed [15:0] origin_torque;
  logic signed [15:0] motor_speed;
  modport source (output valid, target_power, origin_torque, motor_speed, input ready);
  modport sink (input valid, target_power, origin_torque, motor_speed, output ready);
endinterface

interface mtq_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] torque_out;
  logic [1:0]         root_status;
  modport source (output valid, torque_out, root_status, input ready);
  modport sink (input valid, torque_out, root_status, output ready);
endinterface

interface mtq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mtq_pkg::IDX_W-1:0]    index;
  logic [mtq_pkg::COEF_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/motor_torque_from_power_quadratic_unit.sv =====
// Top level: torque from target power by solving the quadratic power model.
// Throughput: one sample per cycle unless the result side stalls; the square
// root takes one bit per stage over 64 stages and each divider one quotient
// bit per stage over 32 stages.
// Any stall on the result side halts the whole solver pipeline at once.
// Reset: synchronous; clears coefficients to zero, the queue and all valids.
module motor_torque_from_power_quadratic_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  mtq_cfg_if.sink       cfg,
  mtq_sample_if.sink    sample,
  mtq_result_if.source  result
);

  mtq_pkg::coef_t       coef;
  logic                 q_in_valid;
  logic                 q_in_ready;
  mtq_pkg::front_item_t q_in_item;
  logic                 q_out_valid;
  logic                 q_out_ready;
  mtq_pkg::front_item_t q_out_item;

  mtq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sample     (sample),
    .push_ready (q_in_ready),
    .push_valid (q_in_valid),
    .push_item  (q_in_item),
    .coef       (coef)
  );

  mtq_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_item   (q_in_item),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_item  (q_out_item)
  );

  mtq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .coef    (coef),
    .q_valid (q_out_valid),
    .q_ready (q_out_ready),
    .q_item  (q_out_item),
    .result  (result)
  );

  a_zero_status: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.root_status == mtq_pkg::ST_K4_ZERO ||
                     result.root_status == mtq_pkg::ST_NO_ROOT)
    |-> result.torque_out == '0)
    else $error("torque not zero for a no-root or zero-K4 result");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |-> !(q_out_valid && q_out_ready))
    else $error("queue popped while the result beat is stalled");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule

// ===== src/mtq_mul.sv =====
// Two-stage unsigned multiplier built from registered 32x32 partial products.
module mtq_mul #(
  parameter int WA = 64,
  parameter int WB = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int WS = 32 * (NA + NB);

  logic [NA*32-1:0] ax;
  logic [NB*32-1:0] bx;
  logic [63:0]      pp [NA][NB];
  logic [WS-1:0]    acc;

  assign ax = (NA*32)'(a);
  assign bx = (NB*32)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= 64'(ax[32*i +: 32]) * 64'(bx[32*j +: 32]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (WS'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[WA+WB-1:0];
    end
  end

endmodule

// ===== src/mtq_front.sv =====
// Front end: coefficient registers, sample intake and per-sample term setup.
module mtq_front (
  input  logic                 clk,
  input  logic                 rst,
  mtq_cfg_if.sink              cfg,
  mtq_sample_if.sink           sample,
  input  logic                 push_ready,
  output logic                 push_valid,
  output mtq_pkg::front_item_t push_item,
  output mtq_pkg::coef_t       coef
);

  logic signed [63:0] k3w;
  logic signed [63:0] k2w;
  logic signed [63:0] p_sh;
  logic signed [31:0] wsq_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mtq_pkg::REG_CONST:     coef.k0 <= cfg.data;
        mtq_pkg::REG_TORQUE:    coef.k1 <= cfg.data;
        mtq_pkg::REG_SPEED:     coef.k2 <= cfg.data;
        mtq_pkg::REG_CROSS:     coef.k3 <= cfg.data;
        mtq_pkg::REG_TORQUE_SQ: coef.k4 <= cfg.data;
        mtq_pkg::REG_SPEED_SQ:  coef.k5 <= cfg.data;
        default: ;
      endcase
    end
  end

  assign k3w      = 64'(coef.k3) * 64'(sample.motor_speed);
  assign k2w      = 64'(coef.k2) * 64'(sample.motor_speed);
  assign wsq_full = 32'(sample.motor_speed) * 32'(sample.motor_speed);
  assign p_sh     = 64'(sample.target_power) <<< 24;

  always_comb begin
    push_item.k4_zero = (coef.k4 == '0);
    push_item.b       = 64'(coef.k1) + k3w;
    push_item.wsq     = wsq_full[30:0];
    push_item.lin     = 64'(coef.k0) + k2w - p_sh;
    push_item.t0      = sample.origin_torque;
  end

  assign push_valid   = sample.valid;
  assign sample.ready = push_ready;

endmodule

// ===== src/mtq_fifo.sv =====
// Short queue between the front end and the solver pipeline.
module mtq_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mtq_pkg::front_item_t in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mtq_pkg::front_item_t out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mtq_pkg::front_item_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/mtq_back.sv =====
// Solver pipeline: discriminant, square root, two dividers and root choice.
module mtq_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mtq_pkg::coef_t       coef,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  mtq_pkg::front_item_t q_item,
  mtq_result_if.source         result
);

  typedef struct packed {
    logic            valid;
    logic [65:0]     rem;
    logic [63:0]     root;
    logic [127:0]    d;
    mtq_pkg::side_t  side;
  } sq_t;

  typedef struct packed {
    logic        neg;
    logic        big;
    logic [48:0] rem;
    logic [31:0] low;
    logic [31:0] q;
  } lane_t;

  typedef struct packed {
    logic           valid;
    mtq_pkg::side_t side;
    lane_t [1:0]    lane;
  } dv_t;

  logic adv;

  logic [63:0]  b_mag;
  logic [47:0]  k5_mag;
  logic [47:0]  k4_mag;
  logic [48:0]  dm;
  logic [127:0] bb;
  logic [78:0]  cq;
  logic [127:0] kc;

  logic                 v1, v2, v3, v4, v5;
  mtq_pkg::side_t       side0, side1, side2, side3, side4, side5;
  logic signed [63:0]   lin1, lin2;
  logic                 k5neg1, k5neg2;
  logic signed [80:0]   cq_s;
  logic signed [80:0]   c_next;
  logic signed [80:0]   c3;
  logic [79:0]          c_mag;
  logic [127:0]         bb3, bb4, bb5;
  logic                 kcneg4, kcneg5;
  logic signed [129:0]  kc_s;
  logic signed [129:0]  d_full;
  mtq_pkg::status_t     status6;

  sq_t sq [65];

  logic                 vn;
  mtq_pkg::side_t       siden;
  logic [64:0]          nmag [2];
  logic                 nneg [2];
  logic signed [65:0]   nb;
  logic signed [65:0]   root_s;
  logic signed [65:0]   n1, n2;

  dv_t dv [33];

  logic                 vs;
  mtq_pkg::side_t       sides;
  logic signed [31:0]   r1, r2;
  logic signed [31:0]   sat_next [2];

  logic signed [31:0]   ref_t;
  logic signed [32:0]   diff1, diff2;
  logic [32:0]          dist1, dist2;
  logic signed [31:0]   torque;

  assign adv     = !result.valid || result.ready;
  assign q_ready = adv;

  assign b_mag  = q_item.b[63] ? (64'd0 - q_item.b) : q_item.b;
  assign k5_mag = coef.k5[47] ? (48'd0 - coef.k5) : coef.k5;
  assign k4_mag = coef.k4[47] ? (48'd0 - coef.k4) : coef.k4;
  assign dm     = {k4_mag, 1'b0};

  always_comb begin
    side0.status = q_item.k4_zero ? mtq_pkg::ST_K4_ZERO : mtq_pkg::ST_TWO_ROOTS;
    side0.b      = q_item.b;
    side0.t0     = q_item.t0;
  end

  mtq_mul #(.WA(64), .WB(64)) u_bb (
    .clk(clk), .en(adv), .a(b_mag), .b(b_mag), .p(bb)
  );

  mtq_mul #(.WA(48), .WB(31)) u_cq (
    .clk(clk), .en(adv), .a(k5_mag), .b(q_item.wsq), .p(cq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign cq_s   = $signed({2'b00, cq});
  assign c_next = 81'(lin2) + (k5neg2 ? -cq_s : cq_s);

  always_ff @(posedge clk) begin
    if (adv) begin
      side1  <= side0;
      lin1   <= q_item.lin;
      k5neg1 <= coef.k5[47];
      side2  <= side1;
      lin2   <= lin1;
      k5neg2 <= k5neg1;
      side3  <= side2;
      c3     <= c_next;
      bb3    <= bb;
    end
  end

  assign c_mag = c3[80] ? 80'(-c3) : 80'(c3);

  mtq_mul #(.WA(80), .WB(48)) u_kc (
    .clk(clk), .en(adv), .a(c_mag), .b(k4_mag), .p(kc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side4  <= side3;
      bb4    <= bb3;
      kcneg4 <= c3[80] ^ coef.k4[47];
      side5  <= side4;
      bb5    <= bb4;
      kcneg5 <= kcneg4;
    end
  end

  assign kc_s   = $signed({kc, 2'b00});
  assign d_full = $signed({2'b00, bb5}) - (kcneg5 ? -kc_s : kc_s);

  always_comb begin
    if (side5.status == mtq_pkg::ST_K4_ZERO) begin
      status6 = mtq_pkg::ST_K4_ZERO;
    end else if (d_full[129]) begin
      status6 = mtq_pkg::ST_NO_ROOT;
    end else if (d_full == '0) begin
      status6 = mtq_pkg::ST_ONE_ROOT;
    end else begin
      status6 = mtq_pkg::ST_TWO_ROOTS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].valid <= 1'b0;
    end else if (adv) begin
      sq[0].valid       <= v5;
      sq[0].rem         <= '0;
      sq[0].root        <= '0;
      sq[0].d           <= d_full[127:0];
      sq[0].side.status <= status6;
      sq[0].side.b      <= side5.b;
      sq[0].side.t0     <= side5.t0;
    end
  end

  for (genvar k = 0; k < 64; k++) begin : g_sqrt
    logic [67:0] remx;
    logic [67:0] trial;
    logic        ge;
    sq_t         nxt;

    always_comb begin
      remx      = {sq[k].rem, sq[k].d[127:126]};
      trial     = {2'b00, sq[k].root, 2'b01};
      ge        = (remx >= trial);
      nxt.valid = sq[k].valid;
      nxt.rem   = ge ? 66'(remx - trial) : remx[65:0];
      nxt.root  = {sq[k].root[62:0], ge};
      nxt.d     = {sq[k].d[125:0], 2'b00};
      nxt.side  = sq[k].side;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq[k+1].valid <= 1'b0;
      end else if (adv) begin
        sq[k+1] <= nxt;
      end
    end
  end

  assign nb     = -(66'(sq[64].side.b));
  assign root_s = $signed({2'b00, sq[64].root});
  assign n1     = nb + root_s;
  assign n2     = nb - root_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (adv) begin
      vn <= sq[64].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      siden   <= sq[64].side;
      nmag[0] <= n1[65] ? 65'(-n1) : 65'(n1);
      nmag[1] <= n2[65] ? 65'(-n2) : 65'(n2);
      nneg[0] <= n1[65] ^ coef.k4[47];
      nneg[1] <= n2[65] ^ coef.k4[47];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].valid <= 1'b0;
    end else if (adv) begin
      dv[0].valid <= vn;
      dv[0].side  <= siden;
      for (int l = 0; l < 2; l++) begin
        dv[0].lane[l].neg <= nneg[l];
        dv[0].lane[l].big <= ({nmag[l], 16'h0000} >= {dm, 32'h0000_0000});
        dv[0].lane[l].rem <= nmag[l][64:16];
        dv[0].lane[l].low <= {nmag[l][15:0], 16'h0000};
        dv[0].lane[l].q   <= '0;
      end
    end
  end

  for (genvar j = 0; j < 32; j++) begin : g_div
    dv_t nxt;

    always_comb begin
      logic [49:0] r2x;
      logic        ge;
      nxt.valid = dv[j].valid;
      nxt.side  = dv[j].side;
      for (int l = 0; l < 2; l++) begin
        r2x              = {dv[j].lane[l].rem, dv[j].lane[l].low[31]};
        ge               = (r2x >= {1'b0, dm});
        nxt.lane[l].neg  = dv[j].lane[l].neg;
        nxt.lane[l].big  = dv[j].lane[l].big;
        nxt.lane[l].rem  = ge ? 49'(r2x - {1'b0, dm}) : r2x[48:0];
        nxt.lane[l].low  = {dv[j].lane[l].low[30:0], 1'b0};
        nxt.lane[l].q    = {dv[j].lane[l].q[30:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].valid <= 1'b0;
      end else if (adv) begin
        dv[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (dv[32].lane[l].neg) begin
        if (dv[32].lane[l].big || (dv[32].lane[l].q > 32'h8000_0000)) begin
          sat_next[l] = 32'sh8000_0000;
        end else begin
          sat_next[l] = $signed(32'd0 - dv[32].lane[l].q);
        end
      end else begin
        if (dv[32].lane[l].big || dv[32].lane[l].q[31]) begin
          sat_next[l] = 32'sh7fff_ffff;
        end else begin
          sat_next[l] = $signed(dv[32].lane[l].q);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (adv) begin
      vs <= dv[32].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sides <= dv[32].side;
      r1    <= sat_next[0];
      r2    <= sat_next[1];
    end
  end

  assign ref_t = $signed({sides.t0, 16'h0000});
  assign diff1 = 33'(ref_t) - 33'(r1);
  assign diff2 = 33'(ref_t) - 33'(r2);
  assign dist1 = diff1[32] ? 33'(-diff1) : 33'(diff1);
  assign dist2 = diff2[32] ? 33'(-diff2) : 33'(diff2);

  always_comb begin
    case (sides.status)
      mtq_pkg::ST_TWO_ROOTS: torque = (dist1 < dist2) ? r1 : r2;
      mtq_pkg::ST_ONE_ROOT:  torque = r2;
      default:               torque = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (adv) begin
      result.valid <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.torque_out  <= torque;
      result.root_status <= sides.status;
    end
  end

endmodule
